// ----- src/rsrv_pkg.sv -----
package rsrv_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IW      = 5;
    localparam int DIV_NW       = 47;
    localparam int DIV_DW       = 32;
    localparam int DIV_CW       = 6;

    localparam logic [6:0]  COMP_NEUTRAL = 7'd50;
    localparam logic [6:0]  COMP_MAX     = 7'd100;
    localparam logic [15:0] ANGLE_FULL   = 16'd36000;
    localparam logic [15:0] ANGLE_HALF   = 16'd18000;
    localparam logic [15:0] ANGLE_Q1     = 16'd9000;
    localparam logic [15:0] ANGLE_Q3     = 16'd27000;
    localparam logic [31:0] CORDIC_GAIN  = 32'h26DD3B6A;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    localparam logic REG_SAFETY_RADIUS = 1'b0;
    localparam logic REG_MIN_RADIUS    = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic              rem_nz;
    } div_rsp_t;

    function automatic logic signed [31:0] atan_cdeg(input logic [ATAN_IW-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd294912000;
            5'd1:    v = 32'sd174096719;
            5'd2:    v = 32'sd91987925;
            5'd3:    v = 32'sd46694507;
            5'd4:    v = 32'sd23437865;
            5'd5:    v = 32'sd11730358;
            5'd6:    v = 32'sd5866610;
            5'd7:    v = 32'sd2933484;
            5'd8:    v = 32'sd1466764;
            5'd9:    v = 32'sd733385;
            5'd10:   v = 32'sd366693;
            5'd11:   v = 32'sd183346;
            5'd12:   v = 32'sd91673;
            5'd13:   v = 32'sd45837;
            5'd14:   v = 32'sd22918;
            5'd15:   v = 32'sd11459;
            5'd16:   v = 32'sd5730;
            5'd17:   v = 32'sd2865;
            5'd18:   v = 32'sd1432;
            5'd19:   v = 32'sd716;
            5'd20:   v = 32'sd358;
            5'd21:   v = 32'sd179;
            5'd22:   v = 32'sd90;
            5'd23:   v = 32'sd45;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/rsrv_div.sv -----
module rsrv_div (
    input  logic                clk,
    input  logic                rst_n,
    input  rsrv_pkg::div_req_t  req,
    output rsrv_pkg::div_rsp_t  rsp
);
    import rsrv_pkg::*;

    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW+1:0] diff;

    assign diff = {1'b0, rem_reg, quo_reg[DIV_NW-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            quo_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            cnt_reg  <= DIV_CW'(DIV_NW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_DW+1])
            begin
                rem_reg <= diff[DIV_DW-1:0];
            end
            else
            begin
                rem_reg <= {rem_reg[DIV_DW-2:0], quo_reg[DIV_NW-1]};
            end
            quo_reg <= {quo_reg[DIV_NW-2:0], ~diff[DIV_DW+1]};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.quo    = quo_reg;
    assign rsp.rem_nz = (rem_reg != '0);

    ap_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
    ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");
    ap_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without work");

endmodule

// ----- src/range_sweep_repulsion_vector.sv -----
// Channel   Direction  Signals                                  Transfer
// s_axis    in         s_tvalid s_tready s_tdata s_tuser        range point or end of sweep
// m_axis    out        m_tvalid m_tready m_tdata                compensation pair
// cfg       in         cfg_valid cfg_ready cfg_index cfg_data   register write
//
// A range point out of radius is dropped; one in radius passes through the
// shift-add rotator and the shared multiplier.
// An end of sweep with no counted point emits a neutral pair; otherwise it
// passes through the bit-pair square root and the 47-step shared divider
// used four times (two of them skipped for a zero vector).
// Reset is asynchronous active low; it clears sums and maximum, sets the safety radius to 1000 and the minimum to 0.
// The output register holds a result while m_tready is low; a new result waits.
module range_sweep_repulsion_vector #(
    parameter int DIST_WIDTH   = 16,
    parameter int ACC_WIDTH    = 32,
    parameter int CORDIC_ITERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // angle_cdeg[15:0], distance_mm[31:16]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // comp_first[6:0], comp_second[13:7], zero[15:14]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import rsrv_pkg::*;

    localparam int MW  = (DIST_WIDTH + 6 > 34) ? DIST_WIDTH + 6 : 34;
    localparam int PW  = 2 * MW;
    localparam int RW  = PW - 30;
    localparam int SW  = ((ACC_WIDTH > RW) ? ACC_WIDTH : RW) + 1;
    localparam int NSW = (ACC_WIDTH > 31) ? ACC_WIDTH : 31;
    localparam int CW  = 34;
    localparam int MSQ = 63;
    localparam int ITW = $clog2(CORDIC_ITERS);

    localparam logic signed [SW-1:0]  ACC_HI = SW'((64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0]  ACC_LO = SW'(-(64'sd1 <<< (ACC_WIDTH - 1)));
    localparam logic signed [NSW-1:0] LIM_P  = NSW'(64'sd1 <<< 30);
    localparam logic signed [NSW-1:0] LIM_N  = NSW'(-(64'sd1 <<< 30));
    localparam logic signed [PW-1:0]  RND    = PW'(64'sd1 <<< 29);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CORDIC, ST_MULX, ST_ADDX, ST_ADDY, ST_SWEEP, ST_NORM,
        ST_SQX, ST_SQY, ST_SQSUM, ST_SQRT, ST_DIVX_ST, ST_DIVX_W, ST_DIVY_ST,
        ST_DIVY_W, ST_CMX, ST_CMXD_ST, ST_CMXD_W, ST_CMY, ST_CMYD_ST, ST_CMYD_W,
        ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [15:0]               safety_radius_reg;
    logic [15:0]               min_radius_reg;
    logic signed [ACC_WIDTH-1:0] x_sum_reg;
    logic signed [ACC_WIDTH-1:0] y_sum_reg;
    logic [DIST_WIDTH-1:0]     max_pen_reg;
    logic [DIST_WIDTH-1:0]     pen_reg;
    logic signed [CW-1:0]      cx_reg;
    logic signed [CW-1:0]      cy_reg;
    logic signed [31:0]        z_reg;
    logic                      neg_reg;
    logic [ITW-1:0]            iter_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [NSW-1:0]     xs_reg;
    logic signed [NSW-1:0]     ys_reg;
    logic [MSQ-1:0]            m_reg;
    logic [MSQ-1:0]            root_reg;
    logic [MSQ-1:0]            bit_reg;
    logic signed [17:0]        ux_reg;
    logic signed [17:0]        uy_reg;
    logic                      sneg_reg;
    logic [6:0]                comp_first_reg;
    logic [6:0]                comp_second_reg;
    logic                      clear_reg;
    logic                      m_tvalid_reg;
    logic [15:0]               m_tdata_reg;

    logic [DIST_WIDTH-1:0]     rad;
    logic [DIST_WIDTH-1:0]     rmin;
    logic [DIST_WIDTH-1:0]     dist_in;
    logic [DIST_WIDTH:0]       d_diff;
    logic [DIST_WIDTH-1:0]     d_val;
    logic [15:0]               ang_red;
    logic signed [16:0]        ang_t;
    logic                      ang_neg;
    logic signed [CW-1:0]      dx;
    logic signed [CW-1:0]      dy;
    logic signed [31:0]        atan_v;
    logic signed [MW-1:0]      mul_a;
    logic signed [MW-1:0]      mul_b;
    logic signed [RW-1:0]      rnd;
    logic signed [SW-1:0]      acc_x;
    logic signed [SW-1:0]      acc_y;
    logic signed [ACC_WIDTH-1:0] sat_x;
    logic signed [ACC_WIDTH-1:0] sat_y;
    logic                      in_lim;
    logic signed [30:0]        xs31;
    logic signed [30:0]        ys31;
    logic [MSQ-1:0]            sq_trial;
    logic signed [DIST_WIDTH+5:0] mp25;
    logic signed [PW-1:0]      cnum;
    logic [DIV_NW:0]           q_adj;
    logic [6:0]                comp_val;
    logic                      out_free;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    assign rad     = DIST_WIDTH'(safety_radius_reg);
    assign rmin    = DIST_WIDTH'(min_radius_reg);
    assign dist_in = DIST_WIDTH'(s_tdata[31:16]);
    assign d_diff  = {1'b0, rad} - {1'b0, rmin};
    assign d_val   = (d_diff[DIST_WIDTH] || d_diff == '0) ? DIST_WIDTH'(1) : d_diff[DIST_WIDTH-1:0];

    always_comb
    begin
        ang_red = (s_tdata[15:0] >= ANGLE_FULL) ? s_tdata[15:0] - ANGLE_FULL : s_tdata[15:0];
        ang_neg = 1'b0;
        if (ang_red > ANGLE_Q3)
        begin
            ang_t = $signed({1'b0, ang_red}) - $signed({1'b0, ANGLE_FULL});
        end
        else if (ang_red > ANGLE_Q1)
        begin
            ang_t   = $signed({1'b0, ang_red}) - $signed({1'b0, ANGLE_HALF});
            ang_neg = 1'b1;
        end
        else
        begin
            ang_t = $signed({1'b0, ang_red});
        end
    end

    assign dx     = cy_reg >>> iter_reg;
    assign dy     = cx_reg >>> iter_reg;
    assign atan_v = atan_cdeg(ATAN_IW'(iter_reg));

    assign xs31 = xs_reg[30:0];
    assign ys31 = ys_reg[30:0];
    assign mp25 = $signed({6'b0, max_pen_reg}) * 6'sd25;

    always_comb
    begin
        case (state_reg)
            ST_MULX:
            begin
                mul_a = MW'($signed({1'b0, pen_reg}));
                mul_b = MW'(cx_reg);
            end
            ST_ADDX:
            begin
                mul_a = MW'($signed({1'b0, pen_reg}));
                mul_b = MW'(cy_reg);
            end
            ST_SQX:
            begin
                mul_a = MW'(xs31);
                mul_b = MW'(xs31);
            end
            ST_SQY:
            begin
                mul_a = MW'(ys31);
                mul_b = MW'(ys31);
            end
            ST_CMX:
            begin
                mul_a = MW'(mp25);
                mul_b = MW'(ux_reg);
            end
            ST_CMY:
            begin
                mul_a = MW'(mp25);
                mul_b = MW'(uy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd   = RW'((prod_reg + RND) >>> 30);
    assign acc_x = SW'(x_sum_reg) + SW'(rnd);
    assign acc_y = SW'(y_sum_reg) + SW'(rnd);
    assign sat_x = (acc_x > ACC_HI) ? ACC_WIDTH'(ACC_HI) :
                   (acc_x < ACC_LO) ? ACC_WIDTH'(ACC_LO) : ACC_WIDTH'(acc_x);
    assign sat_y = (acc_y > ACC_HI) ? ACC_WIDTH'(ACC_HI) :
                   (acc_y < ACC_LO) ? ACC_WIDTH'(ACC_LO) : ACC_WIDTH'(acc_y);

    assign in_lim   = (xs_reg >= LIM_N) && (xs_reg < LIM_P) && (ys_reg >= LIM_N) && (ys_reg < LIM_P);
    assign sq_trial = root_reg + bit_reg;
    assign cnum     = prod_reg >>> 16;

    assign q_adj = {1'b0, div_rsp.quo} + ((sneg_reg && div_rsp.rem_nz) ? (DIV_NW+1)'(1) : '0);
    always_comb
    begin
        if (sneg_reg)
        begin
            comp_val = (q_adj >= (DIV_NW+1)'(COMP_NEUTRAL)) ? 7'd0 : COMP_NEUTRAL - q_adj[6:0];
        end
        else
        begin
            comp_val = (q_adj >= (DIV_NW+1)'(COMP_NEUTRAL)) ? COMP_MAX : COMP_NEUTRAL + q_adj[6:0];
        end
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (state_reg)
            ST_DIVX_ST:
            begin
                div_req.start = 1'b1;
                div_req.num   = {(xs31[30] ? -DIV_NW'(xs31) : DIV_NW'(xs31))} << 16;
                div_req.den   = root_reg[DIV_DW-1:0];
            end
            ST_DIVY_ST:
            begin
                div_req.start = 1'b1;
                div_req.num   = {(ys31[30] ? -DIV_NW'(ys31) : DIV_NW'(ys31))} << 16;
                div_req.den   = root_reg[DIV_DW-1:0];
            end
            ST_CMXD_ST, ST_CMYD_ST:
            begin
                div_req.start = 1'b1;
                div_req.num   = cnum[PW-1] ? DIV_NW'(-cnum) : DIV_NW'(cnum);
                div_req.den   = DIV_DW'(d_val);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    rsrv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            safety_radius_reg <= 16'd1000;
            min_radius_reg    <= 16'd0;
            x_sum_reg         <= '0;
            y_sum_reg         <= '0;
            max_pen_reg       <= '0;
            m_tvalid_reg      <= 1'b0;
            m_tdata_reg       <= '0;
            iter_reg          <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SAFETY_RADIUS: safety_radius_reg <= cfg_data;
                    REG_MIN_RADIUS:    min_radius_reg    <= cfg_data;
                    default:           safety_radius_reg <= safety_radius_reg;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end
            prod_reg <= PW'(mul_a) * PW'(mul_b);

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser == OP_SWEEP)
                        begin
                            state_reg <= ST_SWEEP;
                        end
                        else if (dist_in < rad)
                        begin
                            pen_reg   <= rad - dist_in;
                            cx_reg    <= CW'($signed({1'b0, CORDIC_GAIN}));
                            cy_reg    <= '0;
                            z_reg     <= 32'(ang_t) <<< 16;
                            neg_reg   <= ang_neg;
                            iter_reg  <= '0;
                            state_reg <= ST_CORDIC;
                        end
                    end
                end
                ST_CORDIC:
                begin
                    if (iter_reg == ITW'(CORDIC_ITERS - 1))
                    begin
                        // cx holds sine and cy holds cosine from here on
                        if (z_reg >= 0)
                        begin
                            cx_reg <= neg_reg ? -(cy_reg + dy) : cy_reg + dy;
                            cy_reg <= neg_reg ? -(cx_reg - dx) : cx_reg - dx;
                        end
                        else
                        begin
                            cx_reg <= neg_reg ? -(cy_reg - dy) : cy_reg - dy;
                            cy_reg <= neg_reg ? -(cx_reg + dx) : cx_reg + dx;
                        end
                        state_reg <= ST_MULX;
                    end
                    else
                    begin
                        if (z_reg >= 0)
                        begin
                            cx_reg <= cx_reg - dx;
                            cy_reg <= cy_reg + dy;
                            z_reg  <= z_reg - atan_v;
                        end
                        else
                        begin
                            cx_reg <= cx_reg + dx;
                            cy_reg <= cy_reg - dy;
                            z_reg  <= z_reg + atan_v;
                        end
                        iter_reg <= iter_reg + 1'b1;
                    end
                end
                ST_MULX:
                begin
                    state_reg <= ST_ADDX;
                end
                ST_ADDX:
                begin
                    x_sum_reg <= sat_x;
                    state_reg <= ST_ADDY;
                end
                ST_ADDY:
                begin
                    y_sum_reg <= sat_y;
                    if (pen_reg > max_pen_reg)
                    begin
                        max_pen_reg <= pen_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SWEEP:
                begin
                    if (max_pen_reg == rmin)
                    begin
                        comp_first_reg  <= COMP_NEUTRAL;
                        comp_second_reg <= COMP_NEUTRAL;
                        clear_reg       <= 1'b0;
                        state_reg       <= ST_EMIT;
                    end
                    else
                    begin
                        xs_reg    <= NSW'(x_sum_reg);
                        ys_reg    <= NSW'(y_sum_reg);
                        clear_reg <= 1'b1;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (in_lim)
                    begin
                        state_reg <= ST_SQX;
                    end
                    else
                    begin
                        xs_reg <= xs_reg >>> 1;
                        ys_reg <= ys_reg >>> 1;
                    end
                end
                ST_SQX:
                begin
                    state_reg <= ST_SQY;
                end
                ST_SQY:
                begin
                    m_reg     <= prod_reg[MSQ-1:0];
                    state_reg <= ST_SQSUM;
                end
                ST_SQSUM:
                begin
                    m_reg     <= m_reg + prod_reg[MSQ-1:0];
                    root_reg  <= '0;
                    bit_reg   <= MSQ'(1) << (MSQ - 1);
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (m_reg >= sq_trial)
                    begin
                        m_reg    <= m_reg - sq_trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        if ((root_reg == '0) && (m_reg == '0))
                        begin
                            ux_reg    <= 18'sd65536;
                            uy_reg    <= '0;
                            state_reg <= ST_CMX;
                        end
                        else
                        begin
                            state_reg <= ST_DIVX_ST;
                        end
                    end
                end
                ST_DIVX_ST:
                begin
                    state_reg <= ST_DIVX_W;
                end
                ST_DIVX_W:
                begin
                    if (div_rsp.done)
                    begin
                        ux_reg    <= xs31[30] ? -18'(div_rsp.quo) : 18'(div_rsp.quo);
                        state_reg <= ST_DIVY_ST;
                    end
                end
                ST_DIVY_ST:
                begin
                    state_reg <= ST_DIVY_W;
                end
                ST_DIVY_W:
                begin
                    if (div_rsp.done)
                    begin
                        uy_reg    <= ys31[30] ? -18'(div_rsp.quo) : 18'(div_rsp.quo);
                        state_reg <= ST_CMX;
                    end
                end
                ST_CMX:
                begin
                    state_reg <= ST_CMXD_ST;
                end
                ST_CMXD_ST:
                begin
                    sneg_reg  <= cnum[PW-1];
                    state_reg <= ST_CMXD_W;
                end
                ST_CMXD_W:
                begin
                    if (div_rsp.done)
                    begin
                        comp_first_reg <= comp_val;
                        state_reg      <= ST_CMY;
                    end
                end
                ST_CMY:
                begin
                    state_reg <= ST_CMYD_ST;
                end
                ST_CMYD_ST:
                begin
                    sneg_reg  <= cnum[PW-1];
                    state_reg <= ST_CMYD_W;
                end
                ST_CMYD_W:
                begin
                    if (div_rsp.done)
                    begin
                        comp_second_reg <= comp_val;
                        state_reg       <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, comp_second_reg, comp_first_reg};
                        if (clear_reg)
                        begin
                            x_sum_reg   <= '0;
                            y_sum_reg   <= '0;
                            max_pen_reg <= rmin;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    ap_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[6:0] <= COMP_MAX) && (m_tdata[13:7] <= COMP_MAX))
        else $error("compensation out of range");
    ap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_free && clear_reg) |=> (x_sum_reg == '0) && (y_sum_reg == '0))
        else $error("sums not cleared after sweep");
    ap_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT || state_reg == ST_CORDIC) |-> !s_tready)
        else $error("input taken while busy");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import rsrv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;

    typedef struct packed {
        logic        op;
        logic [15:0] angle;
        logic [15:0] dist_mm;
    } scan_item_t;

    typedef struct packed {
        logic [6:0] first;
        logic [6:0] second;
    } comp_pair_t;

    localparam longint ATAN_T [16] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    scan_item_t  scan_queue[$];
    comp_pair_t  comp_expect[$];

    longint      acc_x;
    longint      acc_y;
    longint      peak_pen;
    longint      cur_radius;
    longint      cur_min;

    bit          s_fire;
    bit          cfg_fire;
    bit          quiet;
    int          hold_cnt;
    int          stall_cnt;
    int          mismatches;

    range_sweep_repulsion_vector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void sin_cos(input logic [15:0] cdeg, output longint s,
                                    output longint c);
        longint t;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     neg;
        t = longint'(cdeg) % 36000;
        x = longint'(CORDIC_GAIN);
        y = 0;
        neg = 1'b0;
        if (t > 27000)
            t = t - 36000;
        else if (t > 9000)
        begin
            t = t - 18000;
            neg = 1'b1;
        end
        z = t * 65536;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_T[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_T[i];
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic longint sat_acc(input longint a, input longint b);
        longint sum;
        sum = a + b;
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum;
    endfunction

    function automatic longint int_sqrt(input longint unsigned m);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > m)
            b = b >> 2;
        while (b != 0)
        begin
            if (m >= res + b)
            begin
                m = m - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic logic [6:0] comp_level(input longint u, input longint d);
        longint num;
        longint den;
        longint q;
        longint v;
        num = 25 * peak_pen * u;
        den = d * 65536;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        v = 50 + q;
        if (v < 0)
            v = 0;
        if (v > 100)
            v = 100;
        return v[6:0];
    endfunction

    task automatic predict_transfer(input scan_item_t it);
        longint     pen;
        longint     s;
        longint     c;
        longint     xs;
        longint     ys;
        longint     ux;
        longint     uy;
        longint     r;
        longint     d;
        comp_pair_t res;
        if (it.op == OP_POINT)
        begin
            if (longint'(it.dist_mm) < cur_radius)
            begin
                pen = cur_radius - longint'(it.dist_mm);
                sin_cos(it.angle, s, c);
                acc_x = sat_acc(acc_x, (pen * s + (64'sd1 <<< 29)) >>> 30);
                acc_y = sat_acc(acc_y, (pen * c + (64'sd1 <<< 29)) >>> 30);
                if (pen > peak_pen)
                    peak_pen = pen;
            end
            return;
        end
        if (peak_pen != cur_min)
        begin
            xs = acc_x;
            ys = acc_y;
            while (xs >= (64'sd1 <<< 30) || xs < -(64'sd1 <<< 30) ||
                   ys >= (64'sd1 <<< 30) || ys < -(64'sd1 <<< 30))
            begin
                xs = xs >>> 1;
                ys = ys >>> 1;
            end
            if (xs == 0 && ys == 0)
            begin
                ux = 65536;
                uy = 0;
            end
            else
            begin
                r = int_sqrt(longint'(xs * xs + ys * ys));
                ux = (xs * 65536) / r;
                uy = (ys * 65536) / r;
            end
            d = cur_radius - cur_min;
            if (d < 1)
                d = 1;
            res.first = comp_level(ux, d);
            res.second = comp_level(uy, d);
            acc_x = 0;
            acc_y = 0;
            peak_pen = cur_min;
        end
        else
        begin
            res.first = COMP_NEUTRAL;
            res.second = COMP_NEUTRAL;
        end
        comp_expect.push_back(res);
    endtask

    // input monitor, output checker and watchdog
    always @(posedge clk)
    begin
        scan_item_t item;
        comp_pair_t want;
        bit         m_fire;
        s_fire = s_tvalid && s_tready;
        m_fire = m_tvalid && m_tready;
        if (s_fire)
        begin
            item.op = s_tuser;
            item.angle = s_tdata[15:0];
            item.dist_mm = s_tdata[31:16];
            predict_transfer(item);
        end
        if (m_fire)
        begin
            if (comp_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: first=%0d second=%0d",
                             m_tdata[6:0], m_tdata[13:7]);
            end
            else
            begin
                want = comp_expect.pop_front();
                if (m_tdata[6:0] !== want.first || m_tdata[13:7] !== want.second ||
                    m_tdata[15:14] !== 2'b00)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected first=%0d second=%0d, got %0d %0d (%h)",
                                 want.first, want.second, m_tdata[6:0], m_tdata[13:7],
                                 m_tdata);
                end
            end
        end
        if (s_fire || m_fire || cfg_fire)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= WATCHDOG_LIMIT)
        begin
            $display("[range_sweep_repulsion_vector] ERROR");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        logic       vld;
        scan_item_t cur;
        if (s_fire)
            void'(scan_queue.pop_front());
        if (s_tvalid && !s_fire)
            vld = 1'b1;
        else
            vld = (scan_queue.size() != 0) && (quiet || $urandom_range(0, 99) >= 33);
        cur = (scan_queue.size() != 0) ? scan_queue[0] : '0;
        s_tvalid <= vld;
        s_tuser <= vld ? cur.op : 1'b0;
        s_tdata <= vld ? {cur.dist_mm, cur.angle} : 32'd0;
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= quiet || $urandom_range(0, 99) >= 33;
    end

    task automatic push_item(input logic op, input int angle, input int distance);
        scan_item_t it;
        it.op = op;
        it.angle = angle[15:0];
        it.dist_mm = distance[15:0];
        scan_queue.push_back(it);
    endtask

    task automatic push_sweep(input int npts);
        int ang;
        int dst;
        for (int i = 0; i < npts; i++)
        begin
            ang = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 35999);
            dst = ($urandom_range(0, 3) != 0) ? $urandom_range(0, cur_radius)
                                              : $urandom_range(0, 65535);
            push_item(OP_POINT, ang, dst);
        end
        push_item(OP_SWEEP, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic write_reg(input logic idx, input int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[15:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_fire = 1'b1;
        if (idx == REG_SAFETY_RADIUS)
            cur_radius = value & 16'hFFFF;
        else
            cur_min = value & 16'hFFFF;
        @(negedge clk);
        cfg_fire = 1'b0;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (scan_queue.size() != 0 || comp_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int radii [6];
        int mins  [6];
        int count;
        radii = '{1000, 65535, 1, 2000, 100, 65535};
        mins  = '{0, 0, 0, 1500, 200, 65534};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_cnt = 0;
        stall_cnt = 0;
        mismatches = 0;
        cfg_fire = 1'b0;
        acc_x = 0;
        acc_y = 0;
        peak_pen = 0;
        cur_radius = 1000;
        cur_min = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty sweep right after reset
        push_item(OP_SWEEP, 0, 0);
        drain();
        write_reg(REG_SAFETY_RADIUS, 1000);
        write_reg(REG_MIN_RADIUS, 0);
        push_item(OP_POINT, 0, 0);
        push_item(OP_POINT, 9000, 500);
        push_item(OP_POINT, 18000, 999);
        push_item(OP_POINT, 27000, 1000);
        push_item(OP_POINT, 35999, 65535);
        push_item(OP_SWEEP, 65535, 65535);
        push_item(OP_POINT, 36000, 10);
        push_item(OP_POINT, 65535, 300);
        push_item(OP_POINT, 27001, 700);
        push_item(OP_SWEEP, 0, 0);
        // opposite bearings cancel to a zero vector
        push_item(OP_POINT, 0, 200);
        push_item(OP_POINT, 18000, 200);
        push_item(OP_SWEEP, 0, 0);
        push_item(OP_POINT, 4500, 1000);
        push_item(OP_SWEEP, 0, 0);
        for (int i = 0; i < 30; i++)
            push_item(OP_POINT, 13500, 0);
        push_item(OP_SWEEP, 0, 0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_SAFETY_RADIUS, radii[p]);
            write_reg(REG_MIN_RADIUS, mins[p]);
            quiet = (p == 1);
            if (p == 2)
                hold_cnt = 2000;
            count = 0;
            while (count < 95)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_item(OP_SWEEP, $urandom_range(0, 65535), $urandom_range(0, 65535));
                    count++;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    push_item(OP_POINT, $urandom_range(0, 65535), $urandom_range(0, 65535));
                    count++;
                end
                else
                begin
                    push_sweep($urandom_range(0, 12));
                    count = count + scan_queue.size() - count;
                end
            end
            drain();
            quiet = 1'b0;
        end

        if (mismatches == 0)
            $display("[range_sweep_repulsion_vector] OK");
        else
            $display("[range_sweep_repulsion_vector] ERROR");
        $finish;
    end

endmodule
